// ===== rtl/mpba_pkg.sv =====
package mpba_pkg;

  localparam int unsigned KIB_W    = 13;
  localparam int unsigned BYTES_W  = 23;
  localparam int unsigned TOTAL_W  = 25;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned PROD_W   = 2 * CNT_W;
  localparam int unsigned ALIGN_B  = 3;
  localparam int unsigned CFG_POOLS = 4;
  localparam int unsigned CFG_AW   = 3;

  localparam logic [CODE_W-1:0] ANY_CODE = 3'd4;
  localparam logic [CODE_W-1:0] ANY_POOL = 3'd2;

  localparam logic [KIB_W-1:0] POOL_RESET_KIB [CFG_POOLS] =
    '{13'h0080, 13'h02BF, 13'h0600, 13'h1400};

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_ALLOC_DEF = 2'd1,
    OP_FLUSH     = 2'd2,
    OP_DRAIN     = 2'd3
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_POOL0_SIZE   = 3'd0,
    REG_POOL1_SIZE   = 3'd1,
    REG_POOL2_SIZE   = 3'd2,
    REG_POOL3_SIZE   = 3'd3,
    REG_DEFAULT_POOL = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] pool;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  elem_size;
  } req_t;

  typedef struct packed {
    logic [BYTES_W-1:0] offset;
    logic [BYTES_W-1:0] granted_bytes;
    logic               error;
    logic [TOTAL_W-1:0] total_free;
  } res_t;

  // Pool size in bytes after reset; pools past the configurable ones are empty.
  function automatic logic [BYTES_W-1:0] reset_bytes(input int unsigned idx);
    logic [BYTES_W-1:0] b;
    b = '0;
    for (int unsigned k = 0; k < CFG_POOLS; k++) begin
      if (k == idx) begin
        b = {POOL_RESET_KIB[k], 10'b0};
      end
    end
    return b;
  endfunction

endpackage

// ===== rtl/mpba_cfg_regs.sv =====
module mpba_cfg_regs #(
  parameter int unsigned NUM_POOLS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mpba_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [mpba_pkg::KIB_W-1:0]    cfg_wdata,
  output logic [mpba_pkg::BYTES_W-1:0]  pool_full [NUM_POOLS],
  output logic [mpba_pkg::CODE_W-1:0]   default_pool
);
  import mpba_pkg::*;

  logic [CODE_W-1:0] default_pool_r;

  for (genvar i = 0; i < NUM_POOLS; i++) begin : g_pool
    if (i < CFG_POOLS) begin : g_reg
      logic [KIB_W-1:0] size_kib_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          size_kib_r <= POOL_RESET_KIB[i];
        end else if (cfg_we && cfg_addr == CFG_AW'(i)) begin
          size_kib_r <= cfg_wdata;
        end
      end
      assign pool_full[i] = {size_kib_r, 10'b0};
    end else begin : g_none
      assign pool_full[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_pool_r <= '0;
    end else if (cfg_we && cfg_addr == REG_DEFAULT_POOL) begin
      default_pool_r <= cfg_wdata[CODE_W-1:0];
    end
  end

  assign default_pool = default_pool_r;

endmodule

// ===== rtl/mpba_pool_core.sv =====
module mpba_pool_core #(
  parameter int unsigned NUM_POOLS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  mpba_pkg::req_t                req,
  input  logic [mpba_pkg::BYTES_W-1:0]  pool_full [NUM_POOLS],
  input  logic [mpba_pkg::CODE_W-1:0]   default_pool,
  output mpba_pkg::res_t                res
);
  import mpba_pkg::*;

  localparam int unsigned PIDX_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;

  function automatic logic [TOTAL_W-1:0] total_reset();
    logic [TOTAL_W-1:0] s;
    s = '0;
    for (int unsigned k = 0; k < NUM_POOLS; k++) begin
      s = s + TOTAL_W'(reset_bytes(k));
    end
    return s;
  endfunction

  logic [BYTES_W-1:0] pool_free_r [NUM_POOLS];
  logic [TOTAL_W-1:0] total_r;

  logic [CODE_W-1:0]  code_sel;
  logic [4:0]         code5;
  logic               pool_ok;
  logic [PIDX_W-1:0]  pidx;
  logic [BYTES_W-1:0] cur_free;
  logic [BYTES_W-1:0] full;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  need;
  logic [BYTES_W:0]   drain_g;
  logic               upd;
  logic [BYTES_W-1:0] free_nxt;
  logic [TOTAL_W-1:0] total_nxt;

  always_comb begin
    code_sel = (req.op == OP_ALLOC_DEF) ? default_pool : req.pool;
    code5    = (code_sel == ANY_CODE) ? 5'(ANY_POOL) : 5'(code_sel);
    pool_ok  = 32'(code5) < NUM_POOLS;
    pidx     = code5[PIDX_W-1:0];
    cur_free = pool_ok ? pool_free_r[pidx] : '0;
    full     = pool_ok ? pool_full[pidx] : '0;

    prod     = req.count * req.elem_size;
    // round up to 8 bytes; cannot overflow for 16x16 operands
    need     = {prod[PROD_W-1:ALIGN_B] + (PROD_W-ALIGN_B)'(|prod[ALIGN_B-1:0]),
                {ALIGN_B{1'b0}}};
    drain_g  = {(BYTES_W-ALIGN_B+1)'(cur_free[BYTES_W-1:ALIGN_B])
                + (BYTES_W-ALIGN_B+1)'(|cur_free[ALIGN_B-1:0]), {ALIGN_B{1'b0}}};

    upd               = 1'b0;
    free_nxt          = cur_free;
    res.offset        = '0;
    res.granted_bytes = '0;
    res.error         = 1'b0;

    if (!pool_ok) begin
      res.error = 1'b1;
    end else begin
      unique case (req.op)
        OP_ALLOC, OP_ALLOC_DEF: begin
          if (need >= PROD_W'(cur_free)) begin
            res.error = 1'b1;
          end else begin
            upd               = 1'b1;
            free_nxt          = cur_free - need[BYTES_W-1:0];
            res.offset        = full - cur_free;
            res.granted_bytes = need[BYTES_W-1:0];
          end
        end
        OP_FLUSH: begin
          upd               = 1'b1;
          free_nxt          = full;
          res.granted_bytes = full;
        end
        OP_DRAIN: begin
          upd               = 1'b1;
          free_nxt          = cur_free - drain_g[BYTES_W-1:0];
          res.offset        = full - cur_free;
          res.granted_bytes = drain_g[BYTES_W-1:0];
        end
        default: begin
          res.error = 1'b1;
        end
      endcase
    end

    // running sum: swap the old count of the touched pool for the new one
    total_nxt      = upd ? total_r - TOTAL_W'(cur_free) + TOTAL_W'(free_nxt) : total_r;
    res.total_free = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned i = 0; i < NUM_POOLS; i++) begin
        pool_free_r[i] <= reset_bytes(i);
      end
      total_r <= total_reset();
    end else if (fire && upd) begin
      pool_free_r[pidx] <= free_nxt;
      total_r           <= total_nxt;
    end
  end

endmodule

// ===== rtl/multi_pool_bump_allocator.sv =====
// Bump allocator over NUM_POOLS pools with a free-byte counter per pool.
// Requests are taken one per clock while the sink takes results (operation
// in in_tuser); each yields one result via the input and result registers.
// The combinational multiply, 8-byte align, compare and subtract on the
// counter file set that rate; the pool total is kept as a running sum.
// The user must write pool sizes and the default pool through cfg_* only
// while idle; the block does not enforce this. A new size takes effect at the
// next flush and in offsets right away. Pool code 4 selects pool 2. A refused
// request returns error with zero offset and size and leaves all counters as they were.
module multi_pool_bump_allocator #(
  parameter int unsigned NUM_POOLS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pool[2:0], count[18:3], elem_size[34:19]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // offset[22:0], granted_bytes[45:23], total_free[70:46]
  output logic [0:0]  out_tuser,  // error[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);
  import mpba_pkg::*;

  logic [BYTES_W-1:0] pool_full [NUM_POOLS];
  logic [CODE_W-1:0]  default_pool;

  logic   req_valid_r, req_valid_nxt;
  req_t   req_r;
  logic   out_valid_r, out_valid_nxt;
  res_t   res_r;
  res_t   res;
  logic   adv;
  logic   fire;
  logic   in_acc;

  mpba_cfg_regs #(.NUM_POOLS(NUM_POOLS)) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .pool_full    (pool_full),
    .default_pool (default_pool)
  );

  mpba_pool_core #(.NUM_POOLS(NUM_POOLS)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .req          (req_r),
    .pool_full    (pool_full),
    .default_pool (default_pool),
    .res          (res)
  );

  assign adv       = !out_valid_r || out_tready;
  assign fire      = req_valid_r && adv;
  assign in_tready = !req_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    req_valid_nxt = in_acc ? 1'b1 : (fire ? 1'b0 : req_valid_r);
    out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r.op        <= op_t'(in_tuser);
      req_r.pool      <= in_tdata[2:0];
      req_r.count     <= in_tdata[18:3];
      req_r.elem_size <= in_tdata[34:19];
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.total_free, res_r.granted_bytes, res_r.offset};
  assign out_tuser  = res_r.error;

endmodule

// ===== rtl/mpba_checker.sv =====
module mpba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a result waiting for the sink keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // a refused request carries no offset and no size
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[45:0] == 46'd0)
    else $error("error result with nonzero offset or size");

  a_granted_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[25:23] == 3'd0)
    else $error("granted size not a multiple of 8");

endmodule

bind multi_pool_bump_allocator mpba_checker u_mpba_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mpba_pkg::*;

  localparam int unsigned POOLS = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // pool[2:0], count[18:3], elem_size[34:19]
  logic [1:0]  in_tuser = '0;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // offset[22:0], granted_bytes[45:23], total_free[70:46]
  logic [0:0]  out_tuser;       // error[0]
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [12:0] cfg_wdata = '0;

  multi_pool_bump_allocator #(.NUM_POOLS(POOLS)) u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Shadow of the allocator: sizes, default pool and per-pool free counters
  logic [KIB_W-1:0]   shadow_kib [POOLS];
  logic [CODE_W-1:0]  shadow_dflt;
  logic [BYTES_W-1:0] shadow_free [POOLS];

  req_t req_backlog [$];
  res_t alloc_results_due [$];

  int n_fail = 0;
  int n_grant = 0, n_refused = 0, n_flush = 0, n_drain = 0, n_settings = 1;

  initial begin
    for (int i = 0; i < POOLS; i++) begin
      shadow_kib[i] = POOL_RESET_KIB[i];
      shadow_free[i] = {POOL_RESET_KIB[i], 10'b0};
    end
    shadow_dflt = '0;
  end

  function automatic logic [31:0] round_up8(logic [31:0] v);
    return (v[2:0] != 3'd0) ? ({v[31:3], 3'b000} + 32'd8) : v;
  endfunction

  function automatic res_t predict_allocation(req_t r);
    res_t res;
    logic [CODE_W-1:0] code;
    logic [31:0] need, full, old, diff;
    logic [TOTAL_W-1:0] sum;
    int unsigned p;
    res = '0;
    code = (r.op == OP_ALLOC_DEF) ? shadow_dflt : r.pool;
    if (code == ANY_CODE) code = ANY_POOL;
    if (code >= POOLS) begin
      res.error = 1'b1;
      n_refused++;
    end else begin
      p = code;
      old = {9'd0, shadow_free[p]};
      full = {9'd0, shadow_kib[p], 10'b0};
      diff = full - old;
      case (r.op)
        OP_ALLOC, OP_ALLOC_DEF: begin
          need = round_up8(32'(r.count) * 32'(r.elem_size));
          if (need >= old) begin
            res.error = 1'b1;
            n_refused++;
          end else begin
            res.offset = diff[22:0];
            res.granted_bytes = need[22:0];
            diff = old - need;
            shadow_free[p] = diff[22:0];
            n_grant++;
          end
        end
        OP_FLUSH: begin
          shadow_free[p] = full[22:0];
          res.granted_bytes = full[22:0];
          n_flush++;
        end
        default: begin
          need = round_up8(old);
          res.offset = diff[22:0];
          res.granted_bytes = need[22:0];
          diff = old - need;
          shadow_free[p] = diff[22:0];
          n_drain++;
        end
      endcase
    end
    sum = '0;
    for (int i = 0; i < POOLS; i++) sum += shadow_free[i];
    res.total_free = sum;
    return res;
  endfunction

  // Sender: bursts of requests with random gaps
  req_t drv_req;
  int   burst_left = 1, gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) alloc_results_due.push_back(predict_allocation(drv_req));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          drv_req = req_backlog.pop_front();
          in_tdata <= {5'd0, drv_req.elem_size, drv_req.count, drv_req.pool};
          in_tuser <= drv_req.op;
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches among four random ready patterns; one long hold on request
  logic long_hold_req = 1'b0;
  logic long_hold_taken = 1'b0;
  int   hold_left = 0, rx_mode = 0, rx_left = 0, rx_cyc = 0;

  always @(posedge clk) begin
    rx_cyc++;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(64, 512);
    end else begin
      rx_left--;
    end
    if (long_hold_req && !long_hold_taken) begin
      long_hold_taken = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 4) == 0);
        default: out_tready <= (rx_cyc % 4 == 0);
      endcase
    end
  end

  // Result checker
  res_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (alloc_results_due.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        want = alloc_results_due.pop_front();
        if (out_tdata[22:0] !== want.offset) begin
          $error("offset: expected %0d, got %0d", want.offset, out_tdata[22:0]);
          n_fail++;
        end
        if (out_tdata[45:23] !== want.granted_bytes) begin
          $error("granted_bytes: expected %0d, got %0d", want.granted_bytes, out_tdata[45:23]);
          n_fail++;
        end
        if (out_tuser[0] !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, out_tuser[0]);
          n_fail++;
        end
        if (out_tdata[70:46] !== want.total_free) begin
          $error("total_free: expected %0d, got %0d", want.total_free, out_tdata[70:46]);
          n_fail++;
        end
      end
    end
  end

  task automatic queue_req(op_t op, logic [2:0] pool, logic [15:0] cnt, logic [15:0] esz);
    req_t r;
    r.op = op;
    r.pool = pool;
    r.count = cnt;
    r.elem_size = esz;
    req_backlog.push_back(r);
  endtask

  // Checked just after the edge so the sender's updates have settled
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (req_backlog.size() != 0 || in_tvalid || alloc_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [12:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == REG_DEFAULT_POOL) shadow_dflt = val[2:0];
    else shadow_kib[2'(idx)] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [12:0] pick_kib();
    case ($urandom_range(0, 5))
      0: return 13'd0;
      1: return 13'd8191;
      2: return 13'd1;
      3, 4: return 13'($urandom_range(2, 64));
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int k;
    k = $urandom_range(0, 99);
    r.op = (k < 50) ? OP_ALLOC : (k < 65) ? OP_ALLOC_DEF : (k < 82) ? OP_FLUSH : OP_DRAIN;
    r.pool = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    case ($urandom_range(0, 9))
      0: begin
        r.count = 16'($urandom_range(0, 65535));
        r.elem_size = 16'($urandom_range(0, 65535));
      end
      1: begin
        r.count = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 65535));
        r.elem_size = (r.count != 0) ? 16'd0 : 16'($urandom_range(0, 65535));
      end
      2: begin
        r.count = 16'($urandom_range(0, 4096));
        r.elem_size = 16'($urandom_range(1, 64));
      end
      default: begin
        r.count = 16'($urandom_range(0, 64));
        r.elem_size = 16'($urandom_range(1, 512));
      end
    endcase
    return r;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes: grants, alignment, refusals, bad codes, flush/drain corners
    queue_req(OP_ALLOC, 3'd0, 16'd0, 16'd0);
    queue_req(OP_ALLOC, 3'd0, 16'd3, 16'd5);
    queue_req(OP_ALLOC, 3'd0, 16'd1, 16'd8);
    queue_req(OP_ALLOC, 3'd1, 16'hFFFF, 16'hFFFF);
    queue_req(OP_ALLOC, ANY_CODE, 16'd100, 16'd7);
    queue_req(OP_ALLOC, 3'd5, 16'd1, 16'd1);
    queue_req(OP_FLUSH, 3'd6, 16'd0, 16'd0);
    queue_req(OP_DRAIN, 3'd7, 16'd0, 16'd0);
    queue_req(OP_ALLOC_DEF, 3'd7, 16'd2, 16'd3);
    queue_req(OP_ALLOC, 3'd0, 16'd16384, 16'd8);
    queue_req(OP_DRAIN, 3'd0, 16'd0, 16'd0);
    queue_req(OP_ALLOC, 3'd0, 16'd0, 16'd0);    // zero size on an empty pool
    queue_req(OP_DRAIN, 3'd0, 16'd0, 16'd0);
    queue_req(OP_FLUSH, 3'd0, 16'd0, 16'd0);
    queue_req(OP_ALLOC, 3'd0, 16'd16383, 16'd8); // leaves exactly 8 bytes
    queue_req(OP_ALLOC, 3'd0, 16'd0, 16'd5);
    queue_req(OP_ALLOC, 3'd0, 16'd1, 16'd1);     // equal to free -> refused
    queue_req(OP_FLUSH, ANY_CODE, 16'd0, 16'd0);
    queue_req(OP_DRAIN, ANY_CODE, 16'd0, 16'd0);
    queue_req(OP_ALLOC, 3'd3, 16'hFFFF, 16'd80);
    queue_req(OP_FLUSH, 3'd3, 16'd0, 16'd0);
    wait_drained();

    // extreme sizes; pool 0 shrunk below its free count before a refused alloc and a flush
    write_reg(REG_POOL0_SIZE, 13'd0);
    write_reg(REG_POOL1_SIZE, 13'd8191);
    write_reg(REG_POOL2_SIZE, 13'd1);
    write_reg(REG_POOL3_SIZE, 13'd8191);
    write_reg(REG_DEFAULT_POOL, 13'(ANY_CODE));
    n_settings++;
    queue_req(OP_ALLOC, 3'd0, 16'd1, 16'd1);
    queue_req(OP_FLUSH, 3'd0, 16'd0, 16'd0);
    queue_req(OP_FLUSH, 3'd1, 16'd0, 16'd0);
    queue_req(OP_ALLOC_DEF, 3'd0, 16'd4, 16'd4);
    queue_req(OP_ALLOC, 3'd1, 16'hFFFF, 16'd127);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_POOL0_SIZE, pick_kib());
      write_reg(REG_POOL1_SIZE, pick_kib());
      write_reg(REG_POOL2_SIZE, pick_kib());
      write_reg(REG_POOL3_SIZE, pick_kib());
      write_reg(REG_DEFAULT_POOL, 13'($urandom_range(0, 4)));
      n_settings++;
      if (ph == 2) long_hold_req = 1'b1;
      repeat (235) req_backlog.push_back(random_request());
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d grants, %0d refusals, %0d flushes, %0d drains",
             n_grant, n_refused, n_flush, n_drain);
    $display("across %0d register settings with random source gaps and sink stalls",
             n_settings);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
